[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file of the block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define KAL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is also checked during reset.
`define KAL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/kal_pkg.sv]
// Types, constants and helper functions of the key autorepeat latch.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kal_pkg;

    localparam int NUM_KEYS_DEF  = 64;
    localparam int TIME_BITS_DEF = 48;

    localparam int KEY_W   = 6;
    localparam int SPEED_W = 8;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 1;

    localparam logic [ADDR_W-1:0] REG_TPS = 1'b0;

    localparam logic [DATA_W-1:0] TPS_RESET = 32'd1000000;

    // Timebase: ticks per second split into a quotient and remainder by 60.
    localparam int Q_W = 27;
    localparam int R_W = 6;
    localparam logic [Q_W-1:0] Q_RESET = Q_W'(TPS_RESET / 60);
    localparam logic [R_W-1:0] R_RESET = R_W'(TPS_RESET % 60);

    // Reciprocal of 15 scaled by 2^34, exact for a 30-bit dividend.
    localparam logic [30:0] RECIP15_WIDE = 31'd1145324613;
    localparam int          QPROD_W      = 61;
    // Reciprocal of 15 scaled by 2^18, exact below 11520.
    localparam logic [14:0] RECIP15_NARROW = 15'd17477;

    localparam int P1_W  = SPEED_W + Q_W;
    localparam int PR_W  = 14;
    localparam int V3_W  = 16;
    localparam int F_W   = 10;
    localparam int DLY_W = 37;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               key_ok;
        logic [KEY_W-1:0]   key;
        logic               down;
        logic [SPEED_W-1:0] speed;
    } t_cmd;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic [R_W-1:0] r;
    } t_timebase;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_SCALE,
        B_COMMIT
    } t_bstate;

    // Floor of v / 60 for v below 46080.
    function automatic logic [F_W-1:0] div60_small(input logic [V3_W-1:0] v);
        logic [31:0] prod;
        prod = 32'(v[V3_W-1:2]) * 32'(RECIP15_NARROW);
        return prod[18 +: F_W];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/kal_front.sv]
// Front end: configuration register, timebase precompute and command classify.
// Depends on kal_pkg; feeds kal_queue.
`timescale 1ns / 1ps
`default_nettype none

module kal_front #(
    parameter int NUM_KEYS = kal_pkg::NUM_KEYS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_op,
    input  wire logic [kal_pkg::KEY_W-1:0]  i_key_code,
    input  wire logic                       i_key_down,
    input  wire logic [kal_pkg::SPEED_W-1:0] i_repeat_speed,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kal_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kal_pkg::DATA_W-1:0] pwdata,
    output logic [kal_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  wire kal_pkg::t_qstat            i_qstat,
    output logic                            o_push,
    output kal_pkg::t_cmd                   o_cmd,
    output kal_pkg::t_timebase              o_tb
);
    import kal_pkg::*;

    logic [DATA_W-1:0]  r_tps;
    logic [1:0]         r_busy;
    logic [QPROD_W-1:0] r_qprod;
    t_timebase          r_tb;
    logic               cfg_wr;
    logic [Q_W-1:0]     n_q;
    logic [DATA_W-1:0]  n_rem;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_TPS);
    assign prdata = (paddr == REG_TPS) ? r_tps : '0;

    assign n_q   = r_qprod[34 +: Q_W];
    assign n_rem = r_tps - ((DATA_W'(n_q) << 6) - (DATA_W'(n_q) << 2));

    always_ff @(posedge i_clk) begin
        r_qprod <= QPROD_W'(r_tps[DATA_W-1:2]) * QPROD_W'(RECIP15_WIDE);
        if (!i_rst_n) begin
            r_tps  <= TPS_RESET;
            r_busy <= '0;
            r_tb   <= '{q: Q_RESET, r: R_RESET};
        end else begin
            r_busy <= {r_busy[0], cfg_wr};
            if (cfg_wr) begin
                r_tps <= pwdata;
            end
            if (r_busy[1]) begin
                r_tb <= '{q: n_q, r: n_rem[R_W-1:0]};
            end
        end
    end

    assign o_tb    = r_tb;
    assign o_stall = i_qstat.full || (r_busy != 2'b00);
    assign o_push  = i_valid && !o_stall;

    always_comb begin
        o_cmd.op     = t_op'(i_op);
        o_cmd.key_ok = (32'(i_key_code) < NUM_KEYS);
        o_cmd.key    = i_key_code;
        o_cmd.down   = i_key_down;
        o_cmd.speed  = i_repeat_speed;
    end

endmodule

`default_nettype wire

[hw/rtl/kal_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on kal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kal_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire kal_pkg::t_cmd   i_cmd,
    input  wire logic            i_pop,
    output kal_pkg::t_cmd        o_head,
    output kal_pkg::t_qstat      o_qstat
);
    import kal_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/kal_back.sv]
// Back end: tick counter, per-key phase bits, deadline memory and query unit.
// Depends on kal_pkg; takes commands from kal_queue.
`timescale 1ns / 1ps
`default_nettype none

module kal_back #(
    parameter int NUM_KEYS  = kal_pkg::NUM_KEYS_DEF,
    parameter int TIME_BITS = kal_pkg::TIME_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kal_pkg::t_cmd      i_head,
    input  wire kal_pkg::t_qstat    i_qstat,
    input  wire kal_pkg::t_timebase i_tb,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_fire
);
    import kal_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    t_bstate              r_state;
    t_bstate              n_state;
    logic [TIME_BITS-1:0] r_now;
    logic [NUM_KEYS-1:0]  r_pressed;
    logic [NUM_KEYS-1:0]  r_latched;
    logic [NUM_KEYS-1:0]  r_armed;
    logic [TIME_BITS-1:0] r_dl_mem [NUM_KEYS];
    logic [TIME_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_key_ok;
    logic [SPEED_W-1:0]   r_speed;
    logic [P1_W-1:0]      r_p1;
    logic [PR_W-1:0]      r_pr;
    logic [F_W-1:0]       r_f1;
    logic [F_W-1:0]       r_f3;
    logic                 r_passed;
    logic [DLY_W-1:0]     r_delay;
    logic                 r_out_valid;
    logic                 r_fire;

    logic [IDX_W-1:0]           head_idx;
    logic [IDX_W+KEY_W-1:0]     head_ext;
    logic                       out_free;
    logic                       commit;
    logic [TIME_BITS-1:0]       diff;
    logic [TIME_BITS+DLY_W-1:0] delay_ext;
    logic [TIME_BITS-1:0]       delay_t;
    logic [TIME_BITS-1:0]       base;
    logic                       cur_pressed;
    logic                       cur_armed;
    logic                       do_arm;
    logic                       do_repeat;
    logic                       dl_we;

    assign head_ext  = {{IDX_W{1'b0}}, i_head.key};
    assign head_idx  = head_ext[IDX_W-1:0];
    assign out_free  = !r_out_valid || !i_stall;
    assign diff      = r_now - r_rd_data;
    assign delay_ext = {{TIME_BITS{1'b0}}, r_delay};
    assign delay_t   = delay_ext[TIME_BITS-1:0];

    assign cur_pressed = r_pressed[r_idx];
    assign cur_armed   = r_armed[r_idx];
    assign do_arm      = r_key_ok && cur_pressed && !cur_armed;
    assign do_repeat   = r_key_ok && cur_pressed && cur_armed &&
                         (r_speed != '0) && r_passed;
    assign base        = cur_armed ? r_rd_data : r_now;
    assign dl_we       = commit && (do_arm || do_repeat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    if (i_head.op == OP_QUERY) begin
                        n_state = B_FETCH;
                    end
                end
            end
            B_FETCH: n_state = B_SCALE;
            B_SCALE: n_state = B_COMMIT;
            B_COMMIT: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_dl_mem[head_idx];
        end
        if (dl_we) begin
            r_dl_mem[r_idx] <= base + delay_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx    <= head_idx;
            r_key_ok <= i_head.key_ok;
            r_speed  <= i_head.speed;
            r_p1     <= P1_W'(i_head.speed) * P1_W'(i_tb.q);
            r_pr     <= PR_W'(i_head.speed) * PR_W'(i_tb.r);
        end
        if (r_state == B_FETCH) begin
            r_passed <= !diff[TIME_BITS-1];
            r_f1     <= div60_small(V3_W'(r_pr));
            r_f3     <= div60_small((V3_W'(r_pr) << 1) + V3_W'(r_pr));
        end
        if (r_state == B_SCALE) begin
            if (cur_armed) begin
                r_delay <= DLY_W'(r_p1) + DLY_W'(r_f1);
            end else begin
                r_delay <= (DLY_W'(r_p1) << 1) + DLY_W'(r_p1) + DLY_W'(r_f3);
            end
        end
        if (commit) begin
            r_fire <= do_arm || do_repeat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_pressed   <= '0;
            r_latched   <= '0;
            r_armed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                unique case (i_head.op)
                    OP_TICK: r_now <= r_now + TIME_BITS'(1);
                    OP_SAMPLE: begin
                        if (i_head.key_ok) begin
                            if (!i_head.down) begin
                                r_pressed[head_idx] <= 1'b0;
                                r_latched[head_idx] <= 1'b0;
                            end else if (!r_latched[head_idx]) begin
                                r_pressed[head_idx] <= 1'b1;
                            end
                        end
                    end
                    OP_QUERY: begin
                    end
                    OP_CLEAR: begin
                        r_pressed <= '0;
                        r_latched <= '1;
                        r_armed   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (commit && r_key_ok) begin
                if (!cur_pressed) begin
                    r_armed[r_idx] <= 1'b0;
                end else if (do_arm) begin
                    r_armed[r_idx] <= 1'b1;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_fire  = r_fire;

endmodule

`default_nettype wire

[hw/rtl/key_autorepeat_latch.sv]
// Top level of the key autorepeat latch: front end, command queue, back end.
// Depends on kal_pkg, kal_front, kal_queue and kal_back.
// Each input word is a tick, a key sample, a query or a clear of all keys; only a
// query yields a result word (fire). Words enter a two-entry queue, so the port
// takes a word per cycle while the queue has room and no ticks_per_second write is
// pending. The back end executes a tick, sample or clear as it pops it; a query
// steps through deadline read with the scaling multiplies, fraction divide by 60
// with the deadline compare, delay sum and deadline update (held while the output
// is stalled); the next word is popped only after it. A write of ticks_per_second
// holds the input stalled while the timebase divide by 60 is recomputed.
// Deadline storage needs no clearing pass after reset; per-key armed bits mask it.
`timescale 1ns / 1ps
`default_nettype none

module key_autorepeat_latch #(
    parameter int NUM_KEYS  = kal_pkg::NUM_KEYS_DEF,
    parameter int TIME_BITS = kal_pkg::TIME_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_op,
    input  wire logic [kal_pkg::KEY_W-1:0]   i_key_code,
    input  wire logic                        i_key_down,
    input  wire logic [kal_pkg::SPEED_W-1:0] i_repeat_speed,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_fire,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kal_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [kal_pkg::DATA_W-1:0]  pwdata,
    output logic [kal_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import kal_pkg::*;

    t_qstat    qstat;
    t_cmd      push_cmd;
    t_cmd      head;
    t_timebase tb;
    logic      push;
    logic      pop;

    kal_front #(
        .NUM_KEYS(NUM_KEYS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_key_code    (i_key_code),
        .i_key_down    (i_key_down),
        .i_repeat_speed(i_repeat_speed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .o_tb          (tb)
    );

    kal_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_head (head),
        .o_qstat(qstat)
    );

    kal_back #(
        .NUM_KEYS (NUM_KEYS),
        .TIME_BITS(TIME_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .i_qstat(qstat),
        .i_tb   (tb),
        .o_pop  (pop),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_fire (o_fire)
    );

endmodule

`default_nettype wire

[hw/rtl/kal_checker.sv]
// Port-level checker for the key autorepeat latch, bound to the top level.
// Depends on kal_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kal_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_stall,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic                       o_fire,
    input wire logic                       psel,
    input wire logic                       penable,
    input wire logic                       pwrite,
    input wire logic                       pready,
    input wire logic [kal_pkg::ADDR_W-1:0] paddr
);
    import kal_pkg::*;

    property p_out_hold;
        o_valid && i_stall |=> o_valid && $stable(o_fire);
    endproperty

    property p_in_hold;
        i_valid && o_stall |=> i_valid;
    endproperty

    property p_reset_idle;
        !i_rst_n |=> !o_valid && !o_stall;
    endproperty

    property p_cfg_stall;
        psel && penable && pwrite && pready && (paddr == REG_TPS) |=> o_stall;
    endproperty

    `KAL_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "Stalled result word changed.")

    `KAL_ASSERT(a_in_hold, i_clk, i_rst_n, p_in_hold, "Stalled input word withdrawn.")

    `KAL_ASSERT_NR(a_reset_idle, i_clk, p_reset_idle, "Block not idle after reset.")

    `KAL_ASSERT(a_cfg_stall, i_clk, i_rst_n, p_cfg_stall, "Input not stalled after a write.")

endmodule

bind key_autorepeat_latch kal_checker u_kal_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_fire (o_fire),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .pready (pready),
    .paddr  (paddr)
);

`default_nettype wire
